[sv/bgd_pkg.sv]
`default_nettype none

package bgd_pkg;

  localparam int unsigned CfgWidth = 7;
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned IntegWidth = 8;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_TOUCH1 = 4'd1,
    PH_GAP1   = 4'd2,
    PH_TOUCH2 = 4'd3,
    PH_GAP2   = 4'd4,
    PH_HELD1  = 4'd5,
    PH_HELD2  = 4'd6,
    PH_LONG1  = 4'd7,
    PH_LONG2  = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_PRESS1 = 3'd1,
    EV_CLICK1 = 3'd2,
    EV_LONG1  = 3'd3,
    EV_PRESS2 = 3'd4,
    EV_CLICK2 = 3'd5,
    EV_LONG2  = 3'd6
  } event_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_PRESS_DEBOUNCE = 3'd0,
    CFG_FIRST_PRESS    = 3'd1,
    CFG_BOUNCE_RELEASE = 3'd2,
    CFG_CLICK_GAP      = 3'd3,
    CFG_DOUBLE_RELEASE = 3'd4,
    CFG_LONG_PRESS     = 3'd5,
    CFG_HOLD_RELEASE   = 3'd6
  } cfg_idx_e;

  localparam logic [CfgWidth-1:0] RstPressDebounce = 7'd8;
  localparam logic [CfgWidth-1:0] RstFirstPress    = 7'd16;
  localparam logic [CfgWidth-1:0] RstBounceRelease = 7'd3;
  localparam logic [CfgWidth-1:0] RstClickGap      = 7'd25;
  localparam logic [CfgWidth-1:0] RstDoubleRelease = 7'd8;
  localparam logic [CfgWidth-1:0] RstLongPress     = 7'd80;
  localparam logic [CfgWidth-1:0] RstHoldRelease   = 7'd10;

  localparam logic signed [IntegWidth:0] IntegMax = 9'sd127;
  localparam logic signed [IntegWidth:0] IntegMin = -9'sd128;

  typedef struct packed {
    logic [CfgWidth-1:0] press_debounce;
    logic [CfgWidth-1:0] first_press;
    logic [CfgWidth-1:0] bounce_release;
    logic [CfgWidth-1:0] click_gap;
    logic [CfgWidth-1:0] double_release;
    logic [CfgWidth-1:0] long_press;
    logic [CfgWidth-1:0] hold_release;
  } cfg_t;

  typedef struct packed {
    phase_e                        phase;
    event_e                        evt;
    logic signed [IntegWidth-1:0]  integ;
  } state_t;

  typedef struct packed {
    phase_e phase;
    event_e evt;
    logic   released;
    logic   touched;
    logic   touched_still;
    logic   single_long;
    logic   double_long;
  } result_t;

endpackage

`default_nettype wire

[sv/button_gesture_detector_unit.sv]
`default_nettype none

// button gesture detector: takes one item per clock, either a sample tick
// carrying the raw button level (opcode 0) or an end-of-frame mark (opcode 1)
// that clears the latched event. each accepted sample tick updates the gesture
// phase, the latched event and the saturating integrator in the cycle it is
// accepted, and every item's result (phase, event and query flags) shows up in
// the output register on the next cycle. sustained rate is one item per
// cycle; the state update and the one-deep output register set that
// figure, and input is only held off while a result sits untaken.
// thresholds: seven 7-bit registers on the plain write port (index 0..6);
// the user must write them only while no item is in flight; not enforced here.
module button_gesture_detector_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [bgd_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [bgd_pkg::CfgWidth-1:0]      cfg_data_i,
  // input item channel
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              opcode_i,
  input  wire logic                              level_i,
  // result item channel
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [3:0]                             phase_o,
  output logic [2:0]                             event_res_o,
  output logic                                   released_o,
  output logic                                   touched_o,
  output logic                                   touched_still_o,
  output logic                                   single_long_o,
  output logic                                   double_long_o
);

  bgd_pkg::cfg_t    cfg;
  bgd_pkg::state_t  st_q, st_d;
  bgd_pkg::result_t res_q, res_d;
  logic             out_valid_q, out_valid_d;
  logic             in_fire;

  // threshold registers
  bgd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // one-item update of the gesture state and result flags
  bgd_step u_step (
    .opcode_i (opcode_i),
    .level_i  (level_i),
    .cfg_i    (cfg),
    .st_i     (st_q),
    .st_o     (st_d),
    .res_o    (res_d)
  );

  // take a new item whenever the result slot is empty or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // gesture state, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase  <= bgd_pkg::PH_IDLE;
      st_q.evt    <= bgd_pkg::EV_NONE;
      st_q.integ  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        st_q <= st_d;
      end
    end
  end

  // result payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_o         = res_q.phase;
  assign event_res_o     = res_q.evt;
  assign released_o      = res_q.released;
  assign touched_o       = res_q.touched;
  assign touched_still_o = res_q.touched_still;
  assign single_long_o   = res_q.single_long;
  assign double_long_o   = res_q.double_long;

  // end of frame drops the latched event
  a_eof_clears_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && opcode_i |=> st_q.evt == bgd_pkg::EV_NONE)
    else $error("end of frame did not clear the latched event");

  // end of frame leaves phase and integrator alone
  a_eof_keeps_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && opcode_i |=> st_q.phase == $past(st_q.phase) && st_q.integ == $past(st_q.integ))
    else $error("end of frame disturbed phase or integrator");

  // every phase change restarts the integrator
  a_phase_change_clears_integ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (st_d.phase != st_q.phase) |=> st_q.integ == '0)
    else $error("integrator not cleared on phase change");

  // a shown result carries the phase just stored
  a_result_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> phase_o == st_q.phase && event_res_o == st_q.evt)
    else $error("result register out of step with gesture state");

endmodule

`default_nettype wire

[sv/bgd_cfg.sv]
`default_nettype none

module bgd_cfg (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [bgd_pkg::CfgIdxWidth-1:0]   cfg_index_i,
  input  wire logic [bgd_pkg::CfgWidth-1:0]      cfg_data_i,
  output bgd_pkg::cfg_t                          cfg_o
);

  bgd_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_debounce <= bgd_pkg::RstPressDebounce;
      cfg_q.first_press    <= bgd_pkg::RstFirstPress;
      cfg_q.bounce_release <= bgd_pkg::RstBounceRelease;
      cfg_q.click_gap      <= bgd_pkg::RstClickGap;
      cfg_q.double_release <= bgd_pkg::RstDoubleRelease;
      cfg_q.long_press     <= bgd_pkg::RstLongPress;
      cfg_q.hold_release   <= bgd_pkg::RstHoldRelease;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        bgd_pkg::CFG_PRESS_DEBOUNCE: cfg_q.press_debounce <= cfg_data_i;
        bgd_pkg::CFG_FIRST_PRESS:    cfg_q.first_press    <= cfg_data_i;
        bgd_pkg::CFG_BOUNCE_RELEASE: cfg_q.bounce_release <= cfg_data_i;
        bgd_pkg::CFG_CLICK_GAP:      cfg_q.click_gap      <= cfg_data_i;
        bgd_pkg::CFG_DOUBLE_RELEASE: cfg_q.double_release <= cfg_data_i;
        bgd_pkg::CFG_LONG_PRESS:     cfg_q.long_press     <= cfg_data_i;
        bgd_pkg::CFG_HOLD_RELEASE:   cfg_q.hold_release   <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[sv/bgd_step.sv]
`default_nettype none

module bgd_step (
  input  wire logic     opcode_i,
  input  wire logic     level_i,
  input  wire bgd_pkg::cfg_t   cfg_i,
  input  wire bgd_pkg::state_t st_i,
  output bgd_pkg::state_t st_o,
  output bgd_pkg::result_t res_o
);

  localparam int unsigned W = bgd_pkg::IntegWidth + 1;

  logic signed [W-1:0] sum;
  logic signed [W-1:0] integ;
  logic signed [W-1:0] deb, first, lng;
  logic signed [W-1:0] neg_bounce, neg_gap, neg_dbl, neg_hold;

  // thresholds widened to a common signed compare width
  always_comb begin
    deb        = $signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.press_debounce});
    first      = $signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.first_press});
    lng        = $signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.long_press});
    neg_bounce = -$signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.bounce_release});
    neg_gap    = -$signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.click_gap});
    neg_dbl    = -$signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.double_release});
    neg_hold   = -$signed({{(W-bgd_pkg::CfgWidth){1'b0}}, cfg_i.hold_release});
  end

  // saturating up/down step
  always_comb begin
    sum = $signed({st_i.integ[bgd_pkg::IntegWidth-1], st_i.integ})
          + (level_i ? 9'sd1 : -9'sd1);
    if (sum > bgd_pkg::IntegMax) begin
      integ = bgd_pkg::IntegMax;
    end else if (sum < bgd_pkg::IntegMin) begin
      integ = bgd_pkg::IntegMin;
    end else begin
      integ = sum;
    end
  end

  // next state
  always_comb begin
    st_o = st_i;
    if (opcode_i) begin
      st_o.evt = bgd_pkg::EV_NONE;
    end else begin
      st_o.integ = integ[bgd_pkg::IntegWidth-1:0];
      unique case (st_i.phase)
        bgd_pkg::PH_IDLE: begin
          if (integ < 0) begin
            st_o.integ = '0;
          end else if (integ == deb) begin
            st_o.phase = bgd_pkg::PH_TOUCH1;
            st_o.integ = '0;
          end
        end
        bgd_pkg::PH_TOUCH1: begin
          if (integ == first) begin
            st_o.phase = bgd_pkg::PH_HELD1;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_PRESS1;
          end else if (integ == neg_bounce) begin
            st_o.phase = bgd_pkg::PH_GAP1;
            st_o.integ = '0;
          end
        end
        bgd_pkg::PH_GAP1: begin
          if (integ == deb) begin
            st_o.phase = bgd_pkg::PH_TOUCH2;
            st_o.integ = '0;
          end else if (integ == neg_gap) begin
            st_o.phase = bgd_pkg::PH_IDLE;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_CLICK1;
          end
        end
        bgd_pkg::PH_TOUCH2: begin
          if (integ == deb) begin
            st_o.phase = bgd_pkg::PH_HELD2;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_PRESS2;
          end else if (integ == neg_bounce) begin
            st_o.phase = bgd_pkg::PH_GAP2;
            st_o.integ = '0;
          end
        end
        bgd_pkg::PH_GAP2: begin
          if (integ == deb) begin
            st_o.phase = bgd_pkg::PH_HELD2;
            st_o.integ = '0;
          end else if (integ == neg_dbl) begin
            st_o.phase = bgd_pkg::PH_IDLE;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_CLICK2;
          end
        end
        bgd_pkg::PH_HELD1: begin
          if (integ > lng) begin
            st_o.phase = bgd_pkg::PH_LONG1;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_LONG1;
          end else if (integ == neg_hold) begin
            st_o.phase = bgd_pkg::PH_IDLE;
            st_o.integ = '0;
          end
        end
        bgd_pkg::PH_HELD2: begin
          if (integ > lng) begin
            st_o.phase = bgd_pkg::PH_LONG2;
            st_o.integ = '0;
            st_o.evt   = bgd_pkg::EV_LONG2;
          end else if (integ == neg_hold) begin
            st_o.phase = bgd_pkg::PH_IDLE;
            st_o.integ = '0;
          end
        end
        bgd_pkg::PH_LONG1, bgd_pkg::PH_LONG2: begin
          // drift while held long is dropped
          if (integ > 0) begin
            st_o.integ = '0;
          end else if (integ == neg_hold) begin
            st_o.phase = bgd_pkg::PH_IDLE;
            st_o.integ = '0;
          end
        end
        default: begin
          st_o.phase = bgd_pkg::PH_IDLE;
          st_o.integ = '0;
        end
      endcase
    end
  end

  // query flags from the updated state
  always_comb begin
    res_o.phase    = st_o.phase;
    res_o.evt      = st_o.evt;
    res_o.released = (st_o.phase == bgd_pkg::PH_IDLE) && (st_o.evt == bgd_pkg::EV_NONE);
    res_o.touched  = (st_o.evt == bgd_pkg::EV_PRESS1) || (st_o.evt == bgd_pkg::EV_CLICK1) ||
                     (st_o.evt == bgd_pkg::EV_PRESS2) || (st_o.evt == bgd_pkg::EV_CLICK2);
    res_o.touched_still = res_o.touched ||
                          (st_o.phase == bgd_pkg::PH_HELD1) ||
                          (st_o.phase == bgd_pkg::PH_HELD2) ||
                          (st_o.phase == bgd_pkg::PH_LONG1) ||
                          (st_o.phase == bgd_pkg::PH_LONG2);
    res_o.single_long = (st_o.evt == bgd_pkg::EV_LONG1) || (st_o.phase == bgd_pkg::PH_LONG1);
    res_o.double_long = (st_o.evt == bgd_pkg::EV_LONG2) || (st_o.phase == bgd_pkg::PH_LONG2);
  end

endmodule

`default_nettype wire
